FILE: rtl/core/gtd_pkg.sv
`default_nettype none
package gtd_pkg;

  localparam int COEFF_REGS  = 4;
  localparam int COEFF_W     = 16;
  localparam int FRAC_BITS   = 14;
  localparam int ROUND_HALF  = 8192;
  localparam int STATE_W     = 32;
  localparam int TONE_W      = 2;
  localparam int NTONE_W     = 3;
  localparam int WLEN_W      = 9;
  localparam int MIN_WIN     = 8;
  localparam int POWER_W     = 50;
  localparam int ENERGY_W    = 39;
  localparam int DET_W       = POWER_W + 6;
  localparam int OUT_FIELD_W = POWER_W + ENERGY_W + 1;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
  localparam logic [POWER_W-1:0]  POWER_MAX  = '1;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_COEFF0 = 3'd0;
  localparam logic [2:0] REG_COEFF1 = 3'd1;
  localparam logic [2:0] REG_COEFF2 = 3'd2;
  localparam logic [2:0] REG_COEFF3 = 3'd3;
  localparam logic [2:0] REG_TONES  = 3'd4;
  localparam logic [2:0] REG_WLEN   = 3'd5;

  typedef logic [COEFF_REGS-1:0][COEFF_W-1:0] coeff_arr_t;
  typedef logic [COEFF_REGS-1:0][STATE_W-1:0] tone_state_t;

  typedef struct packed {
    coeff_arr_t          coeff;
    logic [NTONE_W-1:0]  tones;
    logic [WLEN_W-1:0]   wlen;
    logic                wlen_wr;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [NTONE_W-1:0] ntones;
  } pwr_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/gtd_cfg.sv
`default_nettype none
module gtd_cfg
  import gtd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  coeff_arr_t         coeff_r;
  logic [NTONE_W-1:0] tones_r;
  logic [WLEN_W-1:0]  wlen_r;
  logic [2:0]         idx;
  logic               wr;

  assign idx    = paddr[CFG_AW-1:2];
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '0;
      tones_r <= '0;
      wlen_r  <= WLEN_W'(256);
    end else if (wr) begin
      unique case (idx)
        REG_COEFF0: coeff_r[0] <= pwdata[COEFF_W-1:0];
        REG_COEFF1: coeff_r[1] <= pwdata[COEFF_W-1:0];
        REG_COEFF2: coeff_r[2] <= pwdata[COEFF_W-1:0];
        REG_COEFF3: coeff_r[3] <= pwdata[COEFF_W-1:0];
        REG_TONES:  tones_r    <= pwdata[NTONE_W-1:0];
        REG_WLEN:   wlen_r     <= pwdata[WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COEFF0: prdata = CFG_DW'(coeff_r[0]);
      REG_COEFF1: prdata = CFG_DW'(coeff_r[1]);
      REG_COEFF2: prdata = CFG_DW'(coeff_r[2]);
      REG_COEFF3: prdata = CFG_DW'(coeff_r[3]);
      REG_TONES:  prdata = CFG_DW'(tones_r);
      REG_WLEN:   prdata = CFG_DW'(wlen_r);
      default:    prdata = '0;
    endcase
  end

  assign cfg.coeff   = coeff_r;
  assign cfg.tones   = tones_r;
  assign cfg.wlen    = wlen_r;
  // restart the window fill on the same edge the length is written (acted on only while idle)
  assign cfg.wlen_wr = wr && (idx == REG_WLEN);

endmodule
`default_nettype wire

FILE: rtl/core/gtd_lane.sv
`default_nettype none
module gtd_lane
  import gtd_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          clr,
  input  wire logic                          step,
  input  wire logic signed [SAMPLE_BITS-1:0] x,
  input  wire logic signed [COEFF_W-1:0]     coeff,
  output logic signed      [STATE_W-1:0]     s1,
  output logic signed      [STATE_W-1:0]     s2
);

  localparam int PROD_W = COEFF_W + STATE_W;
  localparam int RND_W  = PROD_W + 1;
  localparam int SUM_W  = STATE_W + 6;

  logic signed [STATE_W-1:0] s1_r;
  logic signed [STATE_W-1:0] s2_r;
  logic signed [PROD_W-1:0]  prod;
  logic signed [RND_W-1:0]   prod_rnd;
  logic signed [SUM_W-1:0]   s0_wide;
  logic signed [STATE_W-1:0] s0_sat;
  logic [SUM_W-STATE_W:0]    top_bits;

  always_comb begin
    prod     = PROD_W'(coeff) * PROD_W'(s1_r);
    // round half up, then floor by the fraction width
    prod_rnd = RND_W'(prod) + RND_W'(ROUND_HALF);
    s0_wide  = SUM_W'(x) + SUM_W'(prod_rnd >>> FRAC_BITS) - SUM_W'(s2_r);
    top_bits = s0_wide[SUM_W-1:STATE_W-1];
    if ((&top_bits) || !(|top_bits)) begin
      s0_sat = s0_wide[STATE_W-1:0];
    end else if (s0_wide[SUM_W-1]) begin
      s0_sat = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      s0_sat = {1'b0, {(STATE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      s1_r <= '0;
      s2_r <= '0;
    end else if (step) begin
      s2_r <= s1_r;
      s1_r <= s0_sat;
    end
  end

  assign s1 = s1_r;
  assign s2 = s2_r;

endmodule
`default_nettype wire

FILE: rtl/core/gtd_pwr.sv
`default_nettype none
module gtd_pwr
  import gtd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire pwr_ctl_t               ctl,
  input  wire coeff_arr_t             coeff,
  input  wire tone_state_t            s1,
  input  wire tone_state_t            s2,
  input  wire logic [ENERGY_W-1:0]    energy,
  output logic                        done,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // power, window_energy, detected
  output logic [TONE_W-1:0]           out_tuser,  // tone_index
  output logic                        out_tlast
);

  localparam int OP_W   = STATE_W + 1;
  localparam int MP_W   = 2 * OP_W;
  localparam int T_W    = 2 * STATE_W;
  localparam int ACC_W  = 80;

  typedef enum logic [2:0] {
    P_IDLE, P_MUL, P_TAIL, P_FIN, P_DET, P_OUT
  } pstate_t;

  typedef enum logic [2:0] {
    OP_S1S2, OP_S1S1, OP_S2S2, OP_CTLO, OP_CTHI
  } mop_t;

  pstate_t               state_r;
  mop_t                  op_r;
  mop_t                  op_d_r;
  logic                  mul_vld_r;
  logic [TONE_W-1:0]     tone_r;
  logic [NTONE_W-1:0]    nt_r;
  logic signed [MP_W-1:0]  prod_r;
  logic signed [T_W-1:0]   t_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [POWER_W-1:0]    power_r;
  logic [ENERGY_W-1:0]   energy_r;
  logic                  det_r;
  logic                  last_r;
  logic                  out_tvalid_r;

  logic signed [STATE_W-1:0] sel_s1;
  logic signed [STATE_W-1:0] sel_s2;
  logic signed [COEFF_W-1:0] sel_c;
  logic signed [OP_W-1:0]    mul_a;
  logic signed [OP_W-1:0]    mul_b;
  logic signed [MP_W-1:0]    prod_nxt;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [T_W-1:0]     t_nxt;
  logic [POWER_W-1:0]        power_nxt;
  logic [DET_W-1:0]          p_scaled;
  logic                      det_nxt;
  logic                      out_hs;

  assign sel_s1 = s1[tone_r];
  assign sel_s2 = s2[tone_r];
  assign sel_c  = coeff[tone_r];

  // operand select for the shared multiplier
  always_comb begin
    unique case (op_r)
      OP_S1S2: begin mul_a = OP_W'(sel_s1); mul_b = OP_W'(sel_s2); end
      OP_S1S1: begin mul_a = OP_W'(sel_s1); mul_b = OP_W'(sel_s1); end
      OP_S2S2: begin mul_a = OP_W'(sel_s2); mul_b = OP_W'(sel_s2); end
      OP_CTLO: begin mul_a = OP_W'(sel_c);  mul_b = {1'b0, t_r[STATE_W-1:0]}; end
      OP_CTHI: begin mul_a = OP_W'(sel_c);  mul_b = OP_W'($signed(t_r[T_W-1:STATE_W])); end
      default: begin mul_a = '0;            mul_b = '0; end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // acc = 2^14*(s1^2 + s2^2) - c*s1*s2
  always_comb begin
    acc_nxt = acc_r;
    t_nxt   = t_r;
    if (mul_vld_r) begin
      unique case (op_d_r)
        OP_S1S2: t_nxt   = prod_r[T_W-1:0];
        OP_S1S1: acc_nxt = acc_r + (ACC_W'(prod_r) <<< FRAC_BITS);
        OP_S2S2: acc_nxt = acc_r + (ACC_W'(prod_r) <<< FRAC_BITS);
        OP_CTLO: acc_nxt = acc_r - ACC_W'(prod_r);
        OP_CTHI: acc_nxt = acc_r - (ACC_W'(prod_r) <<< STATE_W);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (acc_r[ACC_W-1]) begin
      power_nxt = '0;
    end else if (|acc_r[ACC_W-1:POWER_W+FRAC_BITS]) begin
      power_nxt = POWER_MAX;
    end else begin
      power_nxt = acc_r[POWER_W+FRAC_BITS-1:FRAC_BITS];
    end
    // power * 50 as shifts and adds
    p_scaled = DET_W'({power_r, 5'b0}) + DET_W'({power_r, 4'b0}) + DET_W'({power_r, 1'b0});
    det_nxt  = (energy != '0) && (p_scaled > DET_W'(energy));
  end

  assign out_hs = out_tvalid_r & out_tready;
  assign done   = (state_r == P_OUT) & out_hs & last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= P_IDLE;
      mul_vld_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
      op_r         <= OP_S1S2;
      op_d_r       <= OP_S1S2;
      tone_r       <= '0;
      nt_r         <= '0;
    end else begin
      mul_vld_r <= (state_r == P_MUL);
      op_d_r    <= op_r;
      unique case (state_r)
        P_IDLE: begin
          if (ctl.start) begin
            nt_r    <= ctl.ntones;
            tone_r  <= '0;
            op_r    <= OP_S1S2;
            state_r <= P_MUL;
          end
        end
        P_MUL: begin
          unique case (op_r)
            OP_S1S2: op_r <= OP_S1S1;
            OP_S1S1: op_r <= OP_S2S2;
            OP_S2S2: op_r <= OP_CTLO;
            OP_CTLO: op_r <= OP_CTHI;
            default: state_r <= P_TAIL;
          endcase
        end
        P_TAIL: state_r <= P_FIN;
        P_FIN:  state_r <= P_DET;
        P_DET: begin
          out_tvalid_r <= 1'b1;
          last_r       <= ({1'b0, tone_r} + NTONE_W'(1)) == nt_r;
          state_r      <= P_OUT;
        end
        P_OUT: begin
          if (out_hs) begin
            out_tvalid_r <= 1'b0;
            if (last_r) begin
              state_r <= P_IDLE;
            end else begin
              tone_r  <= tone_r + TONE_W'(1);
              op_r    <= OP_S1S2;
              state_r <= P_MUL;
            end
          end
        end
        default: state_r <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    t_r    <= t_nxt;
    if ((state_r == P_IDLE) || (state_r == P_OUT)) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
    if (state_r == P_FIN) begin
      power_r <= power_nxt;
    end
    if (state_r == P_DET) begin
      det_r    <= det_nxt;
      energy_r <= energy;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'({det_r, energy_r, power_r});
  assign out_tuser  = tone_r;
  assign out_tlast  = last_r;

endmodule
`default_nettype wire

FILE: rtl/core/sliding_goertzel_tone_detector.sv
// Sliding-window multi-tone Goertzel detector.
// in_*  : one signed sample per word in in_tdata. A sample is written into a
//         circular window of window_len entries (clamped to 8..WINDOW_DEPTH).
// out_* : up to four words per sample once the window has filled, one per
//         tone in use; out_tuser is the tone index, out_tlast marks the last.
// cfg_* : register port for the four Q2.14 coefficients, tones_in_use and
//         window_len. Writing window_len while idle restarts the window fill.
// Timing: while the window is filling, or with no tones in use, a sample is
//         taken and gives no result. With a full window the window memory
//         is read one entry a cycle into the recurrence lanes (all tones at
//         once), then a single shared multiplier works out each tone's power
//         in five products. The power is saturated and registered, compared
//         with the window energy for the detect flag, and the tone's word is
//         then offered on out_*; the next tone starts once it is taken.
//         in_tready stays low from the accepted sample until the last result
//         word has been taken.
// Stall: a result word holds on out_* until out_tready; the block waits.
// Reset: window position and fill flag clear, registers take reset values.
//        The window memory is not cleared; with window_len written only while idle, every entry is written before read.
`default_nettype none
module sliding_goertzel_tone_detector
  import gtd_pkg::*;
#(
  parameter int WINDOW_DEPTH = 256,
  parameter int NUM_TONES    = 4,
  parameter int SAMPLE_BITS  = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,   // sample
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [OUT_TDATA_W-1:0]                   out_tdata,  // power, window_energy, detected
  output logic [TONE_W-1:0]                        out_tuser,  // tone_index
  output logic                                     out_tlast,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [CFG_AW-1:0]                   cfg_paddr,
  input  wire logic [CFG_DW-1:0]                   cfg_pwdata,
  output logic [CFG_DW-1:0]                        cfg_prdata,
  output logic                                     cfg_pready
);

  localparam int AW     = $clog2(WINDOW_DEPTH);
  localparam int PW     = AW + 1;
  localparam int WL_W   = (PW > WLEN_W) ? PW : WLEN_W;
  localparam int NL     = (NUM_TONES > COEFF_REGS) ? COEFF_REGS : NUM_TONES;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int ESUM_W = ((SQ_W > ENERGY_W) ? SQ_W : ENERGY_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RUN, S_DRAIN, S_SUM, S_PWR
  } state_t;

  state_t                         state_r;
  logic [AW-1:0]                  wr_pos_r;
  logic [AW-1:0]                  rd_pos_r;
  logic [PW-1:0]                  cnt_r;
  logic                           full_r;
  logic                           rd_vld_r;
  logic                           sq_vld_r;
  logic signed [SAMPLE_BITS-1:0]  rd_data_r;
  logic [SQ_W-1:0]                sq_r;
  logic [ENERGY_W-1:0]            energy_r;
  logic signed [SAMPLE_BITS-1:0]  mem [WINDOW_DEPTH];

  cfg_t                           cfg;
  pwr_ctl_t                       pwr_ctl;
  logic                           pwr_done;
  wire tone_state_t               lane_s1;
  wire tone_state_t               lane_s2;

  logic [WL_W-1:0]                wl_ext;
  logic [PW-1:0]                  len;
  logic [PW-1:0]                  wr_inc;
  logic [PW-1:0]                  rd_inc;
  logic                           wr_wrap;
  logic [AW-1:0]                  wr_next;
  logic [AW-1:0]                  rd_next;
  logic [NTONE_W-1:0]             nt;
  logic                           accept;
  logic                           go;
  logic signed [SAMPLE_BITS-1:0]  sample;
  logic [SQ_W-1:0]                sq_nxt;
  logic [ESUM_W-1:0]              e_sum;

  gtd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  always_comb begin
    wl_ext = WL_W'(cfg.wlen);
    if (wl_ext < WL_W'(MIN_WIN)) begin
      len = PW'(MIN_WIN);
    end else if (wl_ext > WL_W'(WINDOW_DEPTH)) begin
      len = PW'(WINDOW_DEPTH);
    end else begin
      len = PW'(wl_ext);
    end
    wr_inc  = {1'b0, wr_pos_r} + PW'(1);
    wr_wrap = (wr_inc == len);
    wr_next = wr_wrap ? '0 : wr_inc[AW-1:0];
    rd_inc  = {1'b0, rd_pos_r} + PW'(1);
    rd_next = (rd_inc == len) ? '0 : rd_inc[AW-1:0];
    nt      = (cfg.tones > NTONE_W'(NL)) ? NTONE_W'(NL) : cfg.tones;
  end

  assign sample    = in_tdata[SAMPLE_BITS-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign go        = (full_r | wr_wrap) & (nt != '0);

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wr_pos_r] <= sample;
    end
    rd_data_r <= mem[rd_pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wr_pos_r <= '0;
      rd_pos_r <= '0;
      cnt_r    <= '0;
      full_r   <= 1'b0;
      rd_vld_r <= 1'b0;
      sq_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == S_RUN);
      sq_vld_r <= rd_vld_r;
      unique case (state_r)
        S_IDLE: begin
          if (cfg.wlen_wr) begin
            wr_pos_r <= '0;
            full_r   <= 1'b0;
          end else if (accept) begin
            wr_pos_r <= wr_next;
            if (wr_wrap) begin
              full_r <= 1'b1;
            end
            if (go) begin
              // oldest sample sits at the next write slot
              rd_pos_r <= wr_next;
              cnt_r    <= '0;
              state_r  <= S_RUN;
            end
          end
        end
        S_RUN: begin
          rd_pos_r <= rd_next;
          cnt_r    <= cnt_r + PW'(1);
          if ((cnt_r + PW'(1)) == len) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: state_r <= S_SUM;
        S_SUM:   state_r <= S_PWR;
        S_PWR: begin
          if (pwr_done) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // window energy: the square is registered, then added into the total with saturation
  assign sq_nxt = SQ_W'(rd_data_r) * SQ_W'(rd_data_r);
  assign e_sum  = ESUM_W'(energy_r) + ESUM_W'(sq_r);

  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
    if (accept && go) begin
      energy_r <= '0;
    end else if (sq_vld_r) begin
      energy_r <= (e_sum > ESUM_W'(ENERGY_MAX)) ? ENERGY_MAX : e_sum[ENERGY_W-1:0];
    end
  end

  for (genvar k = 0; k < COEFF_REGS; k++) begin : g_lane
    if (k < NL) begin : g_on
      gtd_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
        .clk   (clk),
        .clr   (accept && go),
        .step  (rd_vld_r),
        .x     (rd_data_r),
        .coeff ($signed(cfg.coeff[k])),
        .s1    (lane_s1[k]),
        .s2    (lane_s2[k])
      );
    end else begin : g_off
      assign lane_s1[k] = '0;
      assign lane_s2[k] = '0;
    end
  end

  assign pwr_ctl.start  = (state_r == S_SUM);
  assign pwr_ctl.ntones = nt;

  gtd_pwr u_pwr (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (pwr_ctl),
    .coeff      (cfg.coeff),
    .s1         (lane_s1),
    .s2         (lane_s2),
    .energy     (energy_r),
    .done       (pwr_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

FILE: rtl/core/gtd_chk.sv
`default_nettype none
module gtd_chk
  import gtd_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [TONE_W-1:0]      out_tuser,
  input wire logic                   out_tlast
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed under stall");

  // no sample taken while results are pending
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a result is pending");

  // a result never follows an accepted sample in the next cycle
  a_in_then_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("result appeared right after a sample");

  // the last word of a burst ends the burst
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("result word after last");

endmodule

bind sliding_goertzel_tone_detector gtd_chk u_gtd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
